[rtl/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int unsigned ADDR_W           = 48;
    localparam int unsigned DESC_W           = 64;
    localparam int unsigned S_TDATA_W        = 112;
    localparam int unsigned M_TDATA_W        = 104;
    localparam int unsigned PA_MASK_BITS_DEF = 36;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_RESPONSE  = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef logic [1:0] level_t;

    localparam level_t LEVEL_0 = 2'd0;
    localparam level_t LEVEL_1 = 2'd1;
    localparam level_t LEVEL_2 = 2'd2;
    localparam level_t LEVEL_3 = 2'd3;

    typedef struct packed {
        logic                op;
        logic [ADDR_W-1:0]   virt_addr;
        logic [DESC_W-1:0]   descriptor;
    } req_t;

    typedef struct packed {
        logic                kind;
        logic [ADDR_W-1:0]   read_addr;
        logic [ADDR_W-1:0]   phys_addr;
        logic                fault;
    } result_t;

endpackage

[rtl/ptw_in_reg.sv]
// ----------------------------------------------------------------------------
// ptw_in_reg
// Input register that holds one request until the walk step takes it.
// ----------------------------------------------------------------------------
module ptw_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ptw_pkg::req_t s_req,
    input  logic          take,
    output logic          valid,
    output ptw_pkg::req_t req
);
    import ptw_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    req_t req_next;

    assign s_ready = !valid_reg || take;
    assign valid   = valid_reg;
    assign req     = req_reg;

    always_comb begin
        valid_next = valid_reg;
        req_next   = req_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            req_next   = s_req;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        req_reg <= req_next;
    end

endmodule

[rtl/ptw_walk_step.sv]
// ----------------------------------------------------------------------------
// ptw_walk_step
// Walk state and the combinational step that turns one request into a result, or drops it.
// ----------------------------------------------------------------------------
module ptw_walk_step #(
    parameter int unsigned PA_MASK_BITS = ptw_pkg::PA_MASK_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ptw_pkg::ADDR_W-1:0]    root_base,
    input  logic                          fire,
    input  ptw_pkg::req_t                 req,
    output logic                          has_result,
    output ptw_pkg::result_t              result
);
    import ptw_pkg::*;

    localparam logic [ADDR_W-1:0] PA_MASK = {ADDR_W{1'b1}} >> (ADDR_W - PA_MASK_BITS);

    logic              busy_reg;
    logic              busy_next;
    level_t            level_reg;
    level_t            level_next;
    logic [ADDR_W-1:0] va_reg;
    logic [ADDR_W-1:0] va_next;
    logic [8:0]        next_index;
    logic [ADDR_W-1:0] table_base;

    assign table_base = {req.descriptor[ADDR_W-1:12], 12'b0};

    always_comb begin
        unique case (level_reg)
            LEVEL_0: next_index = va_reg[38:30];
            LEVEL_1: next_index = va_reg[29:21];
            LEVEL_2: next_index = va_reg[20:12];
            LEVEL_3: next_index = '0;
        endcase
    end

    always_comb begin
        busy_next  = busy_reg;
        level_next = level_reg;
        va_next    = va_reg;
        has_result = 1'b0;
        result     = '0;
        if (req.op == OP_TRANSLATE) begin
            if (!busy_reg) begin
                va_next          = req.virt_addr;
                busy_next        = 1'b1;
                level_next       = LEVEL_0;
                has_result       = 1'b1;
                result.kind      = KIND_READ;
                result.read_addr = {root_base[ADDR_W-1:12], 12'b0}
                                 + {36'b0, req.virt_addr[47:39], 3'b0};
            end
        end else if (busy_reg) begin
            has_result  = 1'b1;
            result.kind = KIND_DONE;
            busy_next   = 1'b0;
            level_next  = LEVEL_0;
            priority if (!req.descriptor[0]) begin
                result.fault = 1'b1;
            end else if (level_reg == LEVEL_1 && !req.descriptor[1]) begin
                result.phys_addr = {req.descriptor[ADDR_W-1:30], va_reg[29:0]};
            end else if (level_reg == LEVEL_2 && !req.descriptor[1]) begin
                result.phys_addr = table_base + {27'b0, va_reg[20:0]};
            end else if (level_reg == LEVEL_3) begin
                result.phys_addr = {req.descriptor[ADDR_W-1:12], va_reg[11:0]} & PA_MASK;
            end else begin
                busy_next        = 1'b1;
                level_next       = level_reg + 2'd1;
                result.kind      = KIND_READ;
                result.read_addr = table_base + {36'b0, next_index, 3'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            level_reg <= LEVEL_0;
        end else if (fire) begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
        end
        if (fire) begin
            va_reg <= va_next;
        end
    end

endmodule

[rtl/ptw_out_reg.sv]
// ----------------------------------------------------------------------------
// ptw_out_reg
// Result register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module ptw_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  ptw_pkg::result_t result,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output ptw_pkg::result_t m_result
);
    import ptw_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;
    result_t result_next;

    assign free     = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        valid_next  = valid_reg;
        result_next = result_reg;
        if (load) begin
            valid_next  = 1'b1;
            result_next = result;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        result_reg <= result_next;
    end

endmodule

[rtl/four_level_page_table_walker.sv]
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Walks a four-level 4 KB-granule page table, one request per cycle while results are taken.
// ----------------------------------------------------------------------------
//  Channel  | Direction | tuser       | tdata (low bit up)
//  s_       | in        | op          | virt_addr[47:0], descriptor[111:48]
//  m_       | out       | kind        | read_addr[47:0], phys_addr[95:48], fault[96]
//  cfg_     | in        | -           | root_table_base[47:0]
//
// A request passes the input register and the result register; one request per
// cycle is sustained while results are taken.
// Synchronous active-low reset clears both registers and leaves the walker idle.
// A stalled result blocks the input only when the next request produces a result.
// ----------------------------------------------------------------------------
module four_level_page_table_walker #(
    parameter int unsigned PA_MASK_BITS = ptw_pkg::PA_MASK_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ptw_pkg::ADDR_W-1:0]      cfg_wr_data,  // root_table_base
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ptw_pkg::S_TDATA_W-1:0]   s_tdata,      // virt_addr, descriptor
    input  logic                            s_tuser,      // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptw_pkg::M_TDATA_W-1:0]   m_tdata,      // read_addr, phys_addr, fault
    output logic                            m_tuser       // kind
);
    import ptw_pkg::*;

    logic [ADDR_W-1:0] root_base_reg;
    req_t              s_req;
    logic              in_valid;
    req_t              in_req;
    logic              step_has_result;
    result_t           step_result;
    logic              out_free;
    logic              advance;
    result_t           m_result;

    assign s_req.op         = s_tuser;
    assign s_req.virt_addr  = s_tdata[ADDR_W-1:0];
    assign s_req.descriptor = s_tdata[ADDR_W+DESC_W-1:ADDR_W];

    assign advance = in_valid && (!step_has_result || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_base_reg <= '0;
        end else if (cfg_wr_en) begin
            root_base_reg <= cfg_wr_data;
        end
    end

    ptw_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_req   (s_req),
        .take    (advance),
        .valid   (in_valid),
        .req     (in_req)
    );

    ptw_walk_step #(
        .PA_MASK_BITS (PA_MASK_BITS)
    ) u_walk_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .root_base  (root_base_reg),
        .fire       (advance),
        .req        (in_req),
        .has_result (step_has_result),
        .result     (step_result)
    );

    ptw_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && step_has_result),
        .result   (step_result),
        .free     (out_free),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tuser = m_result.kind;
    assign m_tdata = {7'b0, m_result.fault, m_result.phys_addr, m_result.read_addr};

endmodule

[rtl/ptw_checker.sv]
// ----------------------------------------------------------------------------
// ptw_checker
// Port-level checks on the result channel of the page table walker.
// ----------------------------------------------------------------------------
module ptw_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ptw_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tuser
);
    import ptw_pkg::*;

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_read_request_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_READ |->
            m_tdata[96] == 1'b0 && m_tdata[95:48] == '0 && m_tdata[2:0] == 3'b0)
        else $error("read request carries walk result bits");

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DONE |->
            m_tdata[47:0] == '0 && (!m_tdata[96] || m_tdata[95:48] == '0))
        else $error("finished result carries stray address bits");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-level page table walker. Walks with random
// virtual addresses and random descriptors go in through the request channel,
// mixed with stray requests that the walker must drop. A scoreboard tracks the
// walk state, predicts every read request and every finished translation, and
// compares the predictions with the results in order. Both channels idle at
// random, and the result side holds off once for a long stretch. The root
// table base is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
    import ptw_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASES         = 6;
    localparam int PHASE_QUOTA    = 310;

    class walk_scoreboard;
        bit [ADDR_W-1:0] root_base;
        bit              walking;
        level_t          level;
        bit [ADDR_W-1:0] held_va;
        result_t         expected_q[$];
        int              errors;

        function new();
            root_base = '0;
            walking   = 1'b0;
            level     = LEVEL_0;
            held_va   = '0;
            errors    = 0;
        endfunction

        function void set_root(bit [ADDR_W-1:0] value);
            root_base = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit [ADDR_W-1:0] entry_addr(bit [ADDR_W-1:0] tbl, level_t lv);
            bit [8:0] idx;
            idx = 9'(held_va >> (39 - 9 * int'(lv)));
            return {tbl[47:12], 12'h000} + {36'h0, idx, 3'b000};
        endfunction

        // Returns 1 when the accepted request produces a result.
        function bit note_request(logic op, bit [ADDR_W-1:0] va, bit [DESC_W-1:0] desc);
            result_t r;
            r = '0;
            if (op == OP_TRANSLATE) begin
                if (walking) return 1'b0;
                held_va     = va;
                walking     = 1'b1;
                level       = LEVEL_0;
                r.kind      = KIND_READ;
                r.read_addr = entry_addr(root_base, LEVEL_0);
            end else begin
                if (!walking) return 1'b0;
                r.kind = KIND_DONE;
                if (!desc[0]) begin
                    r.fault = 1'b1;
                end else if (level == LEVEL_1 && !desc[1]) begin
                    r.phys_addr = {desc[47:30], held_va[29:0]};
                end else if (level == LEVEL_2 && !desc[1]) begin
                    r.phys_addr = {desc[47:12], 12'h000} + {27'h0, held_va[20:0]};
                end else if (level == LEVEL_3) begin
                    r.phys_addr = {desc[47:12], held_va[11:0]}
                                  & ((48'h1 << PA_MASK_BITS_DEF) - 48'h1);
                end else begin
                    level       = level + 2'd1;
                    r.kind      = KIND_READ;
                    r.read_addr = entry_addr(desc[47:0], level);
                end
                if (r.kind == KIND_DONE) begin
                    walking = 1'b0;
                    level   = LEVEL_0;
                end
            end
            expected_q.push_back(r);
            return 1'b1;
        endfunction

        function void compare_field(string name, bit [ADDR_W-1:0] exp_v,
                                    logic [ADDR_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic kind, logic [M_TDATA_W-1:0] data);
            result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual kind %b data %h",
                         $time, kind, data);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("kind", 48'(e.kind), 48'(kind));
            compare_field("read_addr", e.read_addr, data[47:0]);
            compare_field("phys_addr", e.phys_addr, data[95:48]);
            compare_field("fault", 48'(e.fault), 48'(data[96]));
        endfunction
    endclass

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [ADDR_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    walk_scoreboard sb = new();
    bit             idle_on      = 1'b1;
    bit             hold_pending = 1'b0;
    int             productive_requests = 0;
    int             quiet_cycles = 0;

    four_level_page_table_walker DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit [ADDR_W-1:0] rand_va();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic bit [DESC_W-1:0] rand_bits64();
        return {$urandom, $urandom};
    endfunction

    // Mostly valid descriptors so that walks reach the deeper levels.
    function automatic bit [DESC_W-1:0] rand_desc();
        bit [DESC_W-1:0] d;
        d    = {$urandom, $urandom};
        d[0] = ($urandom_range(0, 9) != 0);
        return d;
    endfunction

    task automatic send_request(input logic op, input bit [ADDR_W-1:0] va,
                                input bit [DESC_W-1:0] desc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {desc, va};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (sb.note_request(op, va, desc)) productive_requests++;
    endtask

    task automatic close_walk();
        while (sb.walking) send_request(OP_RESPONSE, rand_va(), 64'h0);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_root(input bit [ADDR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_root(value);
    endtask

    task automatic directed_walks();
        // Every level a table, all-ones fields, level-3 page masked.
        send_request(OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 64'h0);
        repeat (4) send_request(OP_RESPONSE, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        // Level-0 type bit clear still points to a table, then a 1 GB block.
        send_request(OP_TRANSLATE, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_RESPONSE, 48'hFFFF_FFFF_FFFF, 64'h1);
        send_request(OP_RESPONSE, 48'h0, 64'hFFFF_0000_C000_0001);
        // A 2 MB block whose sum wraps past 48 bits.
        send_request(OP_TRANSLATE, 48'h0000_003F_FFFF, 64'h0);
        send_request(OP_RESPONSE, 48'h0, 64'h3);
        send_request(OP_RESPONSE, 48'h0, 64'h3);
        send_request(OP_RESPONSE, 48'h0, 64'h0000_FFFF_FFFF_F001);
        // Translate while busy, fault at level 0, then a response while idle.
        send_request(OP_TRANSLATE, 48'h1234_5678_9ABC, 64'h0);
        send_request(OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 64'h0);
        send_request(OP_RESPONSE, 48'h0, 64'h0);
        send_request(OP_RESPONSE, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        // Fault at level 2 with the ignored low bits set.
        send_request(OP_TRANSLATE, 48'h8040_2010_0804, 64'h0);
        send_request(OP_RESPONSE, 48'h0, 64'h3);
        send_request(OP_RESPONSE, 48'h0, 64'h3);
        send_request(OP_RESPONSE, 48'h0, 64'h0FFC);
        // Level-3 page with its type bit clear.
        send_request(OP_TRANSLATE, 48'hABCD_EF01_2345, 64'h0);
        send_request(OP_RESPONSE, 48'h0, 64'h0000_1234_5678_9003);
        send_request(OP_RESPONSE, 48'h0, 64'h3);
        send_request(OP_RESPONSE, 48'h0, 64'h3);
        send_request(OP_RESPONSE, 48'h0, 64'hFFFF_FFFF_FFFF_F001);
    endtask

    task automatic random_traffic(input int quota);
        int target;
        target = productive_requests + quota;
        while (productive_requests < target) begin
            if ($urandom_range(0, 99) < 8) begin
                send_request(logic'($urandom_range(0, 1)), rand_va(), rand_bits64());
            end else begin
                send_request(OP_TRANSLATE, rand_va(), rand_bits64());
                while (sb.walking) send_request(OP_RESPONSE, rand_va(), rand_desc());
            end
        end
    endtask

    initial begin : result_sink
        int n;
        wait (aresetn);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            n = pick_gap();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no request or result moved", $time);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        bit [ADDR_W-1:0] roots[PHASES];
        roots[0] = 48'hFFFF_FFFF_FFFF;
        roots[1] = rand_va();
        roots[2] = 48'h0;
        roots[3] = 48'h0000_0000_0FFF;
        roots[4] = rand_va();
        roots[5] = rand_va();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_walks();
        for (int p = 0; p < PHASES; p++) begin
            close_walk();
            wait_drained();
            write_root(roots[p]);
            idle_on = (p != 1 && p != 4);
            if (p == 1) hold_pending = 1'b1;
            random_traffic(PHASE_QUOTA);
        end
        close_walk();
        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ptw_pkg.sv
rtl/ptw_in_reg.sv
rtl/ptw_walk_step.sv
rtl/ptw_out_reg.sv
rtl/four_level_page_table_walker.sv
rtl/ptw_checker.sv
verif/testbench.sv
